### rtl/fec_pkg.sv
`timescale 1ns / 1ps
package fec_pkg;
    localparam int TIME_BITS  = 48;
    localparam int ACCEL_BITS = 16;
    localparam int RATE_BITS  = 23;
    localparam int SQ_BITS    = 2 * ACCEL_BITS;
    localparam int MAG_BITS   = SQ_BITS + 2;
    localparam int SC_BITS    = ACCEL_BITS - 5;
    localparam int DOT_BITS   = 2 * SC_BITS + 2;
    localparam int SSQ_BITS   = 2 * SC_BITS + 2;
    localparam int N_REGS     = 8;
    localparam int IDX_BITS   = 3;
    localparam int COS_SQ     = 707 * 707;
    localparam int PERMILLE   = 1000;

    typedef enum logic [1:0] {
        PH_MON    = 2'd0,
        PH_FREE   = 2'd1,
        PH_IMPACT = 2'd2
    } phase_t;

    typedef enum logic [IDX_BITS-1:0] {
        R_FF_LEVEL  = 3'd0,
        R_IMP_LEVEL = 3'd1,
        R_FF_MIN    = 3'd2,
        R_IMP_WIN   = 3'd3,
        R_ST_LOW    = 3'd4,
        R_ST_HIGH   = 3'd5,
        R_ST_GYRO   = 3'd6,
        R_ST_MIN    = 3'd7
    } reg_idx_t;

    // per-lane findings from one axis
    typedef struct packed {
        logic [SQ_BITS-1:0]      sq;
        logic                    gyro_ok;
        logic signed [DOT_BITS-1:0] dot;
        logic [SSQ_BITS-1:0]     bsq;
        logic [SSQ_BITS-1:0]     csq;
    } lane_res_t;

    function automatic logic signed [SC_BITS-1:0] div32(input logic signed [ACCEL_BITS-1:0] v);
        logic signed [ACCEL_BITS-1:0] t;
        t = v < 0 ? v + ACCEL_BITS'(31) : v;
        return SC_BITS'(t >>> 5);
    endfunction
endpackage

### rtl/fec_lane.sv
`timescale 1ns / 1ps
module fec_lane
    import fec_pkg::*;
(
    input  logic                         clk,
    input  logic                         load,
    input  logic signed [ACCEL_BITS-1:0] accel,
    input  logic signed [RATE_BITS-1:0]  rate,
    input  logic signed [ACCEL_BITS-1:0] base,
    input  logic [21:0]                  gyro_limit,
    output lane_res_t                    res
);
    logic signed [SC_BITS-1:0] c, b;
    logic [RATE_BITS-1:0]      ar;

    always_comb
    begin
        c  = div32(accel);
        b  = div32(base);
        ar = rate < 0 ? RATE_BITS'(-rate) : RATE_BITS'(rate);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res.sq      <= SQ_BITS'(accel * accel);
            res.gyro_ok <= ar <= {1'b0, gyro_limit};
            res.dot     <= DOT_BITS'(b * c);
            res.bsq     <= SSQ_BITS'(b * b);
            res.csq     <= SSQ_BITS'(c * c);
        end
    end
endmodule

### rtl/fec_merge.sv
`timescale 1ns / 1ps
// Combines lane results and runs the orientation compare over four stages.
module fec_merge
    import fec_pkg::*;
(
    input  logic          clk,
    input  logic          go,
    input  lane_res_t     l0,
    input  lane_res_t     l1,
    input  lane_res_t     l2,
    output logic [MAG_BITS-1:0] mag_reg,
    output logic          gyro_ok_reg,
    output logic          dot_nonpos_reg,
    output logic          zero_len_reg,
    output logic          cos_ok_reg
);
    logic [DOT_BITS+1:0] dot_reg;
    logic [SSQ_BITS+1:0] bsq_reg, csq_reg;
    logic [DOT_BITS+11:0] d1k_reg;
    logic [2*SSQ_BITS+3:0] p_reg;
    logic [2*DOT_BITS+23:0] lhs_reg;
    logic [2*SSQ_BITS+23:0] rhs_reg;
    logic signed [DOT_BITS+1:0] dsum;
    logic [2:0] st_reg;

    always_comb
        dsum = (DOT_BITS+2)'(l0.dot) + (DOT_BITS+2)'(l1.dot) + (DOT_BITS+2)'(l2.dot);

    always_ff @(posedge clk)
    begin
        st_reg <= {st_reg[1:0], go};
        if (go)
        begin
            mag_reg        <= MAG_BITS'(l0.sq) + MAG_BITS'(l1.sq) + MAG_BITS'(l2.sq);
            gyro_ok_reg    <= l0.gyro_ok & l1.gyro_ok & l2.gyro_ok;
            dot_nonpos_reg <= dsum <= 0;
            dot_reg        <= dsum;
            bsq_reg        <= (SSQ_BITS+2)'(l0.bsq) + (SSQ_BITS+2)'(l1.bsq) + (SSQ_BITS+2)'(l2.bsq);
            csq_reg        <= (SSQ_BITS+2)'(l0.csq) + (SSQ_BITS+2)'(l1.csq) + (SSQ_BITS+2)'(l2.csq);
        end
        if (st_reg[0])
        begin
            d1k_reg      <= (DOT_BITS+12)'(dot_reg) * (DOT_BITS+12)'(PERMILLE);
            p_reg        <= (2*SSQ_BITS+4)'(bsq_reg) * (2*SSQ_BITS+4)'(csq_reg);
            zero_len_reg <= bsq_reg == '0 || csq_reg == '0;
        end
        if (st_reg[1])
        begin
            lhs_reg <= (2*DOT_BITS+24)'(d1k_reg) * (2*DOT_BITS+24)'(d1k_reg);
            rhs_reg <= (2*SSQ_BITS+24)'(p_reg) * (2*SSQ_BITS+24)'(COS_SQ);
        end
        if (st_reg[2])
            cos_ok_reg <= (2*SSQ_BITS+24)'(lhs_reg) <= rhs_reg;
    end
endmodule

### rtl/fall_event_classifier.sv
`timescale 1ns / 1ps
// Fall classifier: one input beat in, one result beat out, one sample in flight at a time.
// The accepted beat loads three axis lanes (square, division by 32, dot and length terms) at
// the accepting edge; a four-stage merge pipeline then forms the magnitude, the gyro check
// and the orientation compare, and after a spare wait the phase update registers and
// presents the result beat. Once the result is taken, s_axis_tready comes back in the cycle
// after, so a new sample is accepted only when the previous result beat has been taken.
// Configuration writes belong between samples.
module fall_event_classifier
    import fec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [167:0] s_axis_tdata, // sample_time, accel_x/y/z, rate_x/y/z
    input  logic        s_axis_tuser,  // enabled
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // fall_detected, phase_after
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    typedef enum logic [1:0] { S_IDLE, S_WAIT, S_OUT } st_t;
    st_t st_reg;
    logic [2:0] cnt_reg;
    logic [14:0] ffl_reg, iml_reg, stl_reg, sth_reg;
    logic [31:0] ffmin_reg, win_reg, stmin_reg;
    logic [21:0] gyro_reg;
    logic [167:0] d_reg;
    logic en_reg;
    phase_t phase_reg;
    logic bvalid_reg, srun_reg, turned_reg;
    logic signed [ACCEL_BITS-1:0] base_reg [3];
    logic [TIME_BITS-1:0] ffs_reg, imp_reg, sst_reg;
    logic [7:0] out_reg;
    lane_res_t lr [3];
    logic [MAG_BITS-1:0] mag;
    logic gok, dnp, zl, cok;

    assign s_axis_tready = st_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = st_reg == S_OUT;
    assign m_axis_tdata = out_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        fec_lane u_lane (
            .clk(clk), .load(s_axis_tvalid && s_axis_tready),
            .accel(s_axis_tdata[48+16*i +: 16]), .rate(s_axis_tdata[96+23*i +: 23]),
            .base(base_reg[i]), .gyro_limit(gyro_reg), .res(lr[i]));
    end

    fec_merge u_merge (
        .clk(clk), .go(st_reg == S_WAIT && cnt_reg == 3'd0), .l0(lr[0]), .l1(lr[1]),
        .l2(lr[2]), .mag_reg(mag), .gyro_ok_reg(gok), .dot_nonpos_reg(dnp),
        .zero_len_reg(zl), .cos_ok_reg(cok));

    logic [TIME_BITS-1:0] now;
    logic ff, imp, still, turn;
    logic [TIME_BITS-1:0] dtf, dti, dts;
    always_comb
    begin
        now   = d_reg[47:0];
        ff    = mag <= MAG_BITS'(ffl_reg * ffl_reg);
        imp   = mag >= MAG_BITS'(iml_reg * iml_reg);
        still = mag >= MAG_BITS'(stl_reg * stl_reg) && mag <= MAG_BITS'(sth_reg * sth_reg) && gok;
        turn  = bvalid_reg && (dnp || (!zl && cok));
        dtf   = now - ffs_reg;
        dti   = now - imp_reg;
        dts   = now - sst_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; cnt_reg <= '0;
            ffl_reg <= 15'd350; iml_reg <= 15'd2500; ffmin_reg <= 32'd100000;
            win_reg <= 32'd1500000; stl_reg <= 15'd800; sth_reg <= 15'd1200;
            gyro_reg <= 22'd100000; stmin_reg <= 32'd3000000;
            phase_reg <= PH_MON; bvalid_reg <= 1'b0; srun_reg <= 1'b0; turned_reg <= 1'b0;
            base_reg[0] <= '0; base_reg[1] <= '0; base_reg[2] <= '0;
            ffs_reg <= '0; imp_reg <= '0; sst_reg <= '0;
            d_reg <= '0; en_reg <= 1'b0; out_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (reg_idx_t'(cfg_index))
                    R_FF_LEVEL:  ffl_reg   <= cfg_data[14:0];
                    R_IMP_LEVEL: iml_reg   <= cfg_data[14:0];
                    R_FF_MIN:    ffmin_reg <= cfg_data;
                    R_IMP_WIN:   win_reg   <= cfg_data;
                    R_ST_LOW:    stl_reg   <= cfg_data[14:0];
                    R_ST_HIGH:   sth_reg   <= cfg_data[14:0];
                    R_ST_GYRO:   gyro_reg  <= cfg_data[21:0];
                    default:     stmin_reg <= cfg_data;
                endcase
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        d_reg <= s_axis_tdata; en_reg <= s_axis_tuser;
                        cnt_reg <= '0; st_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd5)
                    begin
                        logic fall, tb;
                        phase_t np;
                        fall = 1'b0; tb = 1'b0; np = phase_reg;
                        if (!en_reg)
                        begin
                            np = PH_MON; srun_reg <= 1'b0; turned_reg <= 1'b0;
                        end
                        else if (phase_reg == PH_MON)
                        begin
                            tb = 1'b1;
                            if (ff) begin np = PH_FREE; ffs_reg <= now; end
                        end
                        else if (phase_reg == PH_FREE)
                        begin
                            if (imp && dtf >= TIME_BITS'(ffmin_reg))
                            begin
                                np = PH_IMPACT; imp_reg <= now;
                                srun_reg <= 1'b0; turned_reg <= 1'b0;
                            end
                            else if (!ff || dtf > TIME_BITS'(win_reg))
                            begin
                                np = PH_MON; tb = 1'b1;
                                srun_reg <= 1'b0; turned_reg <= 1'b0;
                            end
                        end
                        else if (dti > TIME_BITS'(win_reg) + TIME_BITS'(stmin_reg))
                        begin
                            np = PH_MON; tb = 1'b1; srun_reg <= 1'b0; turned_reg <= 1'b0;
                        end
                        else if (still)
                        begin
                            if ((turn || turned_reg) &&
                                (srun_reg ? dts : '0) >= TIME_BITS'(stmin_reg))
                            begin
                                fall = 1'b1; np = PH_MON;
                                srun_reg <= 1'b0; turned_reg <= 1'b0;
                            end
                            else
                            begin
                                turned_reg <= turned_reg | turn;
                                srun_reg <= 1'b1;
                                if (!srun_reg) sst_reg <= now;
                            end
                        end
                        else
                            srun_reg <= 1'b0;
                        if (tb && still)
                        begin
                            bvalid_reg <= 1'b1;
                            base_reg[0] <= d_reg[63:48];
                            base_reg[1] <= d_reg[79:64];
                            base_reg[2] <= d_reg[95:80];
                        end
                        phase_reg <= np;
                        out_reg <= {5'd0, np, fall};
                        st_reg <= S_OUT;
                    end
                end
                S_OUT:
                    if (m_axis_tready) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    a_out_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:1] == phase_reg) else $error("phase mismatch");
    a_fall_mon: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> phase_reg == PH_MON) else $error("fall phase");
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != S_IDLE |-> !s_axis_tready) else $error("ready busy");
endmodule
